// File: hdl/lphm_pkg.sv
// Shared types and constants for the linear-probing hash map core.
// No dependencies; every other file of the block but lphm_ram imports this package.
package lphm_pkg;

   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int OCC_W      = 8;
   localparam int MARK_W     = 2;
   localparam int ENTRY_W    = MARK_W + KEY_W + VAL_W;
   // home-slot remainder: reciprocal multiply, then multiply back and subtract
   localparam int HASH_STEPS = 2;

   localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PSTART,
      ST_PREAD,
      ST_PEVAL
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic reject;
      logic hash_step;
      logic probe_init;
      logic probe_adv;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic key_zero;
      logic hash_last;
      logic probe_stop;
   } stat_type;

endpackage

// File: hdl/lphm_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing; instanced by the datapath for the slot table.
module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lphm_mod_unit.sv
// Remainder of a 32-bit magnitude by a constant modulus (reciprocal multiply).
// Depends on lphm_pkg; used by the datapath to find a key's home slot.
module lphm_mod_unit #(
   parameter int MODULUS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            step,
   input  logic [lphm_pkg::KEY_W-1:0]      operand,
   output logic                            last,
   output logic [$clog2(MODULUS)-1:0]      remainder
);
   import lphm_pkg::*;

   localparam int IW = $clog2(MODULUS);
   localparam int CW = $clog2(HASH_STEPS);
   localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / 64'(MODULUS));
   localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(MODULUS);

   logic [KEY_W-1:0]   opnd_ff, opnd_in;
   logic [KEY_W-1:0]   quot_ff, quot_in;
   logic [KEY_W-1:0]   rem_ff, rem_in;
   logic [2*KEY_W-1:0] prod;
   logic [KEY_W-1:0]   back;
   logic [KEY_W-1:0]   rem_fix;
   logic [CW-1:0]      cnt_ff, cnt_in;

   // The quotient estimate is low by at most one, so one conditional subtract finishes.
   assign prod    = (2*KEY_W)'(opnd_ff) * (2*KEY_W)'(RECIP);
   assign back    = quot_ff * DIVISOR;
   assign rem_fix = (rem_ff >= DIVISOR) ? rem_ff - DIVISOR : rem_ff;

   always_comb begin
      opnd_in = opnd_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         opnd_in = operand;
         cnt_in  = '0;
      end else if (step) begin
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == '0) begin
            quot_in = prod[2*KEY_W-1:KEY_W];
         end else begin
            rem_in = opnd_ff - back;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      opnd_ff <= opnd_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign last      = (cnt_ff == CW'(HASH_STEPS - 1));
   assign remainder = rem_fix[IW-1:0];

endmodule

// File: hdl/lphm_ctrl.sv
// Controller state machine: table clear, hashing, probe loop and commit sequencing.
// Depends on lphm_pkg; drives the datapath through cmd_type and reads stat_type.
module lphm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lphm_pkg::stat_type stat,
   output lphm_pkg::cmd_type  cmd
);
   import lphm_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && !stat.key_zero) state_in = ST_HASH;
         end
         ST_HASH: begin
            if (stat.hash_last) state_in = ST_PSTART;
         end
         ST_PSTART: state_in = ST_PREAD;
         ST_PREAD:  state_in = ST_PEVAL;
         ST_PEVAL: begin
            state_in = stat.probe_stop ? ST_IDLE : ST_PREAD;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.load   = start;
            cmd.reject = start && stat.key_zero;
         end
         ST_HASH:   cmd.hash_step  = 1'b1;
         ST_PSTART: cmd.probe_init = 1'b1;
         ST_PREAD:  cmd = '0;
         ST_PEVAL: begin
            cmd.commit    = stat.probe_stop;
            cmd.probe_adv = !stat.probe_stop;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/lphm_datapath.sv
// Datapath: request registers, home-slot remainder unit, slot table RAM, probe
// bookkeeping, occupancy count and registered response. Depends on lphm_pkg,
// lphm_ram and lphm_mod_unit.
module lphm_datapath #(
   parameter int SLOTS = 128
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lphm_pkg::cmd_type                       cmd,
   output lphm_pkg::stat_type                      stat,
   input  logic                                    req_mode,
   input  logic signed [lphm_pkg::KEY_W-1:0]       req_key,
   input  logic signed [lphm_pkg::VAL_W-1:0]       req_value,
   output logic                                    rsp_valid,
   output logic [lphm_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [lphm_pkg::VAL_W-1:0]       rsp_removed_value,
   output logic [lphm_pkg::OCC_W-1:0]              rsp_occupied_count
);
   import lphm_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

   logic             mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [KEY_W-1:0] key_bits, key_mag;

   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [IW-1:0] idx_ff, idx_in, idx_next;
   logic [IW-1:0] probe_n_ff, probe_n_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic          free_valid_ff, free_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW+OCC_W-1:0] count_ext;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]    rsp_removed_ff, rsp_removed_in;

   logic [IW-1:0]      home_slot;
   logic               hash_last;
   logic               ram_wr_en;
   logic [IW-1:0]      ram_addr, wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data, rd_data, wr_entry;
   logic               commit_write;

   logic [MARK_W-1:0] rd_mark;
   logic [KEY_W-1:0]  rd_key;
   logic [VAL_W-1:0]  rd_val;
   logic              hit, slot_free, slot_empty, probe_last, free_any;
   logic [IW-1:0]     free_slot;

   assign key_bits = req_key;
   assign key_mag  = key_bits[KEY_W-1] ? (KEY_W'(0) - key_bits) : key_bits;

   lphm_mod_unit #(
      .MODULUS (SLOTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.load),
      .step      (cmd.hash_step),
      .operand   (key_mag),
      .last      (hash_last),
      .remainder (home_slot)
   );

   assign {rd_mark, rd_key, rd_val} = rd_data;

   assign hit        = (rd_mark == MARK_USED) && (rd_key == key_ff);
   assign slot_free  = (rd_mark != MARK_USED);
   assign slot_empty = (rd_mark == MARK_EMPTY);
   assign probe_last = (probe_n_ff == LAST_SLOT);
   assign free_any   = free_valid_ff || slot_free;
   assign free_slot  = free_valid_ff ? free_idx_ff : idx_ff;
   assign idx_next   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + IW'(1);

   assign stat.clr_last   = (clr_idx_ff == LAST_SLOT);
   assign stat.key_zero   = (key_bits == '0);
   assign stat.hash_last  = hash_last;
   assign stat.probe_stop = hit || slot_empty || probe_last;

   // Decide the table write and the response of a finished probe or a rejected request.
   always_comb begin
      commit_write   = 1'b0;
      wr_addr        = idx_ff;
      wr_entry       = {MARK_USED, key_ff, value_ff};
      count_in       = count_ff;
      rsp_status_in  = STATUS_NOT_FOUND;
      rsp_removed_in = '0;
      if (hit) begin
         commit_write = 1'b1;
         if (mode_ff == MODE_REMOVE) begin
            wr_entry       = {MARK_DELETED, key_ff, value_ff};
            rsp_removed_in = rd_val;
            rsp_status_in  = STATUS_REMOVED;
            count_in       = count_ff - CW'(1);
         end else begin
            rsp_status_in = STATUS_UPDATED;
         end
      end else if (mode_ff == MODE_INSERT) begin
         if (free_any) begin
            commit_write  = 1'b1;
            wr_addr       = free_slot;
            rsp_status_in = STATUS_INSERTED;
            count_in      = count_ff + CW'(1);
         end else begin
            rsp_status_in = STATUS_FULL;
         end
      end
      if (cmd.reject) begin
         rsp_status_in  = STATUS_INVALID;
         rsp_removed_in = '0;
         count_in       = count_ff;
      end else if (!cmd.commit) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_addr    = idx_ff;
      ram_wr_data = wr_entry;
      if (cmd.clr_step) begin
         ram_wr_en   = 1'b1;
         ram_addr    = clr_idx_ff;
         ram_wr_data = {MARK_EMPTY, KEY_W'(0), VAL_W'(0)};
      end else if (cmd.commit) begin
         ram_wr_en = commit_write;
         ram_addr  = wr_addr;
      end
   end

   lphm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      clr_idx_in    = cmd.clr_step ? clr_idx_ff + IW'(1) : clr_idx_ff;
      idx_in        = idx_ff;
      probe_n_in    = probe_n_ff;
      free_idx_in   = free_idx_ff;
      free_valid_in = free_valid_ff;
      rsp_valid_in  = cmd.commit || cmd.reject;
      if (cmd.probe_init) begin
         idx_in        = home_slot;
         probe_n_in    = '0;
         free_valid_in = 1'b0;
      end else if (cmd.probe_adv) begin
         // Remember the first reusable slot, then step forward with wrap.
         if (slot_free && !free_valid_ff) begin
            free_idx_in   = idx_ff;
            free_valid_in = 1'b1;
         end
         idx_in     = idx_next;
         probe_n_in = probe_n_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff    <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         free_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff    <= clr_idx_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_valid_ff <= free_valid_in;
      end
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= key_bits;
         value_ff <= req_value;
      end
      idx_ff      <= idx_in;
      probe_n_ff  <= probe_n_in;
      free_idx_ff <= free_idx_in;
      if (cmd.commit || cmd.reject) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_removed_ff <= rsp_removed_in;
      end
   end

   assign count_ext          = {{OCC_W{1'b0}}, count_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_occupied_count = count_ext[OCC_W-1:0];

endmodule

// File: hdl/linear_probe_hash_map_core.sv
// Top level of the linear-probing hash map: controller plus datapath.
// Depends on lphm_pkg, lphm_ctrl and lphm_datapath (with lphm_ram, lphm_mod_unit).
//
// Usage:
//   Request channel: drive req_mode (0 insert/update, 1 remove), req_key and
//   req_value with start high; the transaction is taken at a clock edge where
//   start is high and busy is low. Requests while busy are ignored.
//   Response channel: rsp_valid pulses for one cycle with rsp_status,
//   rsp_removed_value and rsp_occupied_count. The receiver cannot stall it;
//   exactly one response follows each accepted request.
//   Sequence: key zero answers on the cycle after accept. Otherwise the
//   block forms the home-slot remainder (reciprocal multiply, then multiply
//   back and subtract), passes a setup state, then visits slots, each with a
//   single-port table read, then evaluate and commit. A probe visits from 1
//   to SLOTS slots. The next request is taken the cycle the response shows.
//   Reset: synchronous, active high. After reset the block clears the slot
//   table one slot per cycle with busy high, before it takes its first request.
module linear_probe_hash_map_core #(
   parameter int SLOTS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic signed [lphm_pkg::KEY_W-1:0]    req_key,
   input  logic signed [lphm_pkg::VAL_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic [lphm_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [lphm_pkg::VAL_W-1:0]    rsp_removed_value,
   output logic [lphm_pkg::OCC_W-1:0]           rsp_occupied_count
);
   import lphm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lphm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lphm_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_key            (req_key),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_occupied_count (rsp_occupied_count)
   );

endmodule
